FILE: rtl/tkws_pkg.sv
// tkws_pkg: shared widths and the ranked slot type of the top-k weight selector
// no dependencies
package tkws_pkg;

	localparam int WEIGHT_W = 32;
	localparam int COL_W    = 8;
	localparam int SLOT_W   = WEIGHT_W + COL_W;

	// one result slot: weight and the column it came from
	typedef struct packed {
		logic [COL_W-1:0]    column;
		logic [WEIGHT_W-1:0] weight;
	} slot_t;

endpackage

FILE: rtl/top_k_weight_selector_core.sv
// top_k_weight_selector_core: streaming top-k selection over rows of weights
// depends on tkws_pkg, tkws_front, tkws_queue, tkws_back
//
// channel  | dir | tdata                             | tlast
// s_axis   | in  | [31:0] weight (signed q16.16)     | row_end
// m_axis   | out | [31:0] kept_weight, [39:32] column| run_last
//
// one weight per cycle while the row queue is not full; insertion into the keep cells is done in the cycle it arrives
// each row end emits KEEP_COUNT items, one per cycle while m_tready is high, from the output register
// a two-row queue lets the next rows stream in while results drain; input stalls
// only when two finished rows are still waiting
// asynchronous reset clears the column counter, queue and output valid
module top_k_weight_selector_core #(
	parameter int KEEP_COUNT  = 4,
	parameter int MAX_COLUMNS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] weight
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [31:0] kept_weight, [39:32] source_column
	output logic        m_tlast
);

	logic                             accept;
	logic                             push;
	logic                             pop;
	logic                             full;
	logic                             head_valid;
	tkws_pkg::slot_t [KEEP_COUNT-1:0] push_row;
	tkws_pkg::slot_t [KEEP_COUNT-1:0] head_row;
	tkws_pkg::slot_t                  out_slot;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;
	assign m_tdata  = {out_slot.column, out_slot.weight};

	tkws_front #(
		.KEEP_COUNT  (KEEP_COUNT),
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.weight  (s_tdata),
		.row_end (s_tlast),
		.push    (push),
		.row     (push_row)
	);

	tkws_queue #(
		.KEEP_COUNT (KEEP_COUNT)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_row   (push_row),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head_row   (head_row)
	);

	tkws_back #(
		.KEEP_COUNT (KEEP_COUNT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_row   (head_row),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_slot   (out_slot),
		.out_last   (m_tlast)
	);

endmodule

FILE: rtl/tkws_front.sv
// tkws_front: column counter, insertion cells and arrival store of one row
// depends on tkws_pkg; hands a finished row of result slots to the row queue
module tkws_front #(
	parameter int KEEP_COUNT  = 4,
	parameter int MAX_COLUMNS = 256
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  logic [tkws_pkg::WEIGHT_W-1:0]         weight,
	input  logic                                  row_end,
	output logic                                  push,
	output tkws_pkg::slot_t [KEEP_COUNT-1:0]      row
);

	localparam int CNT_W    = $clog2(MAX_COLUMNS + 1);
	localparam int COL_W    = tkws_pkg::COL_W;
	localparam int WEIGHT_W = tkws_pkg::WEIGHT_W;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_COLUMNS);

	logic [CNT_W-1:0]              count_q;
	logic [CNT_W-1:0]              count_d;
	tkws_pkg::slot_t               rank_q    [KEEP_COUNT];
	tkws_pkg::slot_t               rank_d    [KEEP_COUNT];
	logic [WEIGHT_W-1:0]           arrival_q [KEEP_COUNT];
	logic [WEIGHT_W-1:0]           arrival_d [KEEP_COUNT];
	logic [KEEP_COUNT-1:0]         ge;
	logic                          take;
	tkws_pkg::slot_t               new_slot;

	assign take     = accept && (count_q < MAX_CNT);
	assign count_d  = take ? count_q + CNT_W'(1) : count_q;
	assign push     = accept && row_end;
	assign new_slot = '{column: COL_W'(count_q), weight: weight};

	for (genvar i = 0; i < KEEP_COUNT; i++) begin : g_cell
		// held slot ranks at or above the arriving weight
		assign ge[i] = (int'(count_q) > i) && ($signed(rank_q[i].weight) >= $signed(weight));

		always_comb begin
			rank_d[i] = rank_q[i];
			if (take && !ge[i]) begin
				if (i == 0) begin
					rank_d[i] = new_slot;
				end else if (ge[(i == 0) ? 0 : i-1]) begin
					rank_d[i] = new_slot;
				end else begin
					rank_d[i] = rank_q[(i == 0) ? 0 : i-1];
				end
			end
		end

		assign arrival_d[i] = (take && int'(count_q) == i) ? weight : arrival_q[i];

		always_comb begin
			if (int'(count_d) > KEEP_COUNT) begin
				row[i] = rank_d[i];
			end else begin
				row[i].weight = (int'(count_d) > i) ? arrival_d[i] : '0;
				row[i].column = COL_W'(i);
			end
		end

		always_ff @(posedge clk) begin
			rank_q[i]    <= rank_d[i];
			arrival_q[i] <= arrival_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

endmodule

FILE: rtl/tkws_queue.sv
// tkws_queue: two-entry queue of finished rows between front and back
// depends on tkws_pkg
module tkws_queue #(
	parameter int KEEP_COUNT = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  tkws_pkg::slot_t [KEEP_COUNT-1:0] push_row,
	input  logic                             pop,
	output logic                             full,
	output logic                             head_valid,
	output tkws_pkg::slot_t [KEEP_COUNT-1:0] head_row
);

	tkws_pkg::slot_t [KEEP_COUNT-1:0] entry_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full       = cnt_q[1];
	assign head_valid = cnt_q != 2'd0;
	assign head_row   = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/tkws_back.sv
// tkws_back: walks the head row slot by slot into the output register
// depends on tkws_pkg; pops the row queue when its last slot is loaded
module tkws_back #(
	parameter int KEEP_COUNT = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             head_valid,
	input  tkws_pkg::slot_t [KEEP_COUNT-1:0] head_row,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output tkws_pkg::slot_t                  out_slot,
	output logic                             out_last
);

	localparam int IDX_W = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEEP_COUNT - 1);

	logic [IDX_W-1:0] idx_q;
	logic             load;
	logic             at_last;
	tkws_pkg::slot_t  slot_q;
	logic             last_q;
	logic             valid_q;

	assign load    = head_valid && (!valid_q || out_ready);
	assign at_last = idx_q == LAST_IDX;
	assign pop     = load && at_last;

	assign out_valid = valid_q;
	assign out_slot  = slot_q;
	assign out_last  = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= head_row[idx_q];
			last_q <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q   <= at_last ? '0 : idx_q + IDX_W'(1);
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: bench/testbench.sv
// testbench: random and directed rows of weights through top_k_weight_selector_core,
// checked item by item against a built-in top-k predictor
// depends on tkws_pkg and top_k_weight_selector_core
module testbench;

	localparam int KEEP_COUNT  = 4;
	localparam int MAX_COLUMNS = 256;
	localparam int SHORT_ITEMS = 380;
	localparam int IDLE_LIMIT  = 2000;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic [tkws_pkg::WEIGHT_W-1:0] weight;
		logic                          row_end;
	} weight_item_t;

	typedef struct {
		tkws_pkg::slot_t slot;
		logic            run_last;
	} kept_item_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;

	weight_item_t pending_weights[$];
	kept_item_t   kept_expected[$];

	logic [tkws_pkg::WEIGHT_W-1:0] row_arrivals[KEEP_COUNT];
	logic [tkws_pkg::WEIGHT_W-1:0] top_weights[KEEP_COUNT];
	logic [tkws_pkg::COL_W-1:0]    top_columns[KEEP_COUNT];
	logic [8:0]                    row_columns;

	int mismatches  = 0;
	int burst_left  = 0;
	int gap_left    = 0;
	int stall_mode  = 0;
	int stall_left  = 0;
	int idle_cycles = 0;
	int short_count = 0;

	top_k_weight_selector_core #(
		.KEEP_COUNT(KEEP_COUNT),
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void clear_row();
		for (int i = 0; i < KEEP_COUNT; i++) begin
			row_arrivals[i] = '0;
			top_weights[i]  = '0;
			top_columns[i]  = '0;
		end
		row_columns = '0;
	endfunction

	// rank one weight into the keep cells and, at row end, queue the row's results
	function automatic void absorb_weight(logic [tkws_pkg::WEIGHT_W-1:0] w, logic row_end);
		int col;
		int held;
		int pos;
		int n;
		kept_item_t res;
		if (row_columns < MAX_COLUMNS) begin
			col  = row_columns;
			held = (col < KEEP_COUNT) ? col : KEEP_COUNT;
			if (col < KEEP_COUNT)
				row_arrivals[col] = w;
			pos = 0;
			while (pos < held && $signed(top_weights[pos]) >= $signed(w))
				pos++;
			if (pos < KEEP_COUNT) begin
				for (int i = (held < KEEP_COUNT) ? held : KEEP_COUNT - 1; i > pos; i--) begin
					top_weights[i] = top_weights[i-1];
					top_columns[i] = top_columns[i-1];
				end
				top_weights[pos] = w;
				top_columns[pos] = col[tkws_pkg::COL_W-1:0];
			end
			row_columns = 9'(col + 1);
		end
		if (row_end) begin
			n = row_columns;
			for (int i = 0; i < KEEP_COUNT; i++) begin
				if (n > KEEP_COUNT) begin
					res.slot.weight = top_weights[i];
					res.slot.column = top_columns[i];
				end else begin
					res.slot.weight = (i < n) ? row_arrivals[i] : '0;
					res.slot.column = i[tkws_pkg::COL_W-1:0];
				end
				res.run_last = (i == KEEP_COUNT - 1);
				kept_expected.push_back(res);
			end
			clear_row();
		end
	endfunction

	function automatic void push_weight(logic [tkws_pkg::WEIGHT_W-1:0] w, logic row_end);
		weight_item_t it;
		it.weight  = w;
		it.row_end = row_end;
		pending_weights.push_back(it);
	endfunction

	function automatic logic [tkws_pkg::WEIGHT_W-1:0] pick_weight(int mode);
		logic [tkws_pkg::WEIGHT_W-1:0] w;
		case (mode)
			0: w = $urandom;
			1: begin
				case ($urandom_range(0, 5))
					0: w = 32'h8000_0000;
					1: w = 32'h7fff_ffff;
					2: w = 32'hffff_ffff;
					3: w = 32'h0001_0000;
					4: w = 32'h0000_0000;
					default: w = 32'h0000_8000;
				endcase
			end
			default: w = $urandom_range(0, 6) - 3;
		endcase
		return w;
	endfunction

	function automatic void push_row(int len, int mode);
		for (int i = 0; i < len; i++)
			push_weight(pick_weight(mode), i == len - 1);
	endfunction

	// from the last counted column on the strongest weight is sent; past the saturation point it must not show up
	function automatic void push_long_row(int len);
		for (int i = 0; i < len; i++)
			push_weight((i >= MAX_COLUMNS - 1) ? 32'h7fff_ffff : pick_weight(0), i == len - 1);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		weight_item_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				absorb_weight(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_weights.size() > 0) begin
					nxt = pending_weights.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.weight;
					s_tlast  <= nxt.row_end;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 30);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		kept_item_t      want;
		tkws_pkg::slot_t got;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (kept_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected item: weight %h column %0d last %b",
							got.weight, got.column, m_tlast);
				end else begin
					want = kept_expected.pop_front();
					if (got.weight !== want.slot.weight || got.column !== want.slot.column ||
							m_tlast !== want.run_last) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("mismatch: expected %h/%0d/%b got %h/%0d/%b",
								want.slot.weight, want.slot.column, want.run_last,
								got.weight, got.column, m_tlast);
					end
				end
			end
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_left = $urandom_range(20, 150);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ($urandom_range(0, 9) < 3);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		int len;
		clear_row();

		// single weights, both extremes
		push_weight(32'h7fff_ffff, 1'b1);
		push_weight(32'h8000_0000, 1'b1);
		// exactly KEEP_COUNT: arrival order kept
		push_weight(32'h8000_0000, 1'b0);
		push_weight(32'h7fff_ffff, 1'b0);
		push_weight(32'hffff_ffff, 1'b0);
		push_weight(32'h0000_0000, 1'b1);
		// all equal: earlier columns win
		for (int i = 0; i < 5; i++)
			push_weight(32'h0000_0005, i == 4);
		// ranking with ties at the top
		push_weight(32'hffff_ffff, 1'b0);
		push_weight(32'h7fff_ffff, 1'b0);
		push_weight(32'h8000_0000, 1'b0);
		push_weight(32'h7fff_ffff, 1'b0);
		push_weight(32'h0000_0000, 1'b0);
		push_weight(32'h0001_0000, 1'b1);
		// short row: zero padding
		for (int i = 0; i < 3; i++)
			push_weight(32'h0000_0000, i == 2);

		short_count = pending_weights.size();
		while (short_count < SHORT_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1: len = $urandom_range(9, 30);
				2: len = KEEP_COUNT + $urandom_range(0, 1);
				default: len = $urandom_range(1, 8);
			endcase
			push_row(len, $urandom_range(0, 2));
			short_count += len;
			if (short_count >= 40 && short_count - len < 40) begin
				len = MAX_COLUMNS + $urandom_range(1, 40);
				push_long_row(len);
				short_count += len;
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_weights.size() != 0 || s_tvalid)
			@(posedge clk);
		while (kept_expected.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
